[hw/rtl/mss_pkg.sv]
// Shared types and constants for the multitrack step sequencer.
// Used by mss_mod and multitrack_step_sequencer_unit; depends on nothing.
package mss_pkg;

    localparam int TRACKS_DEF = 10;
    localparam int STEPS_DEF  = 16;

    localparam int TIME_W = 32;
    localparam int DIV_W  = 8;
    localparam int KIND_W = 2;
    localparam int OP_W   = 3;
    localparam int TRK_W  = 4;
    localparam int SIDX_W = 4;

    // stream item widths, padded to whole bytes
    localparam int IN_W  = 56;
    localparam int OUT_W = 40;

    localparam logic [DIV_W-1:0] DIV_RESET = 8'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_RESUME  = 3'd3,
        OP_WRITE   = 3'd4,
        OP_DIVIDER = 3'd5
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_EMPTY = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_JUMP  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WSTEP,
        S_DIV,
        S_TRK_RD,
        S_TRK_EVAL,
        S_STEP0,
        S_DECIDE,
        S_FLUSH
    } t_state;

endpackage

[hw/rtl/mss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mss_mod.sv]
// Iterative remainder unit: tick count modulo an 8-bit divider, one bit a cycle.
// Depends on mss_pkg.
module mss_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mss_pkg::TIME_W-1:0] i_dividend,
    input  logic [mss_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [mss_pkg::DIV_W-1:0]  o_rem
);
    import mss_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  n_rem;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_dvd[TIME_W-1]};
        diff  = trial - {1'b0, r_div};
        n_rem = (trial >= {1'b0, r_div}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/multitrack_step_sequencer_unit.sv]
// Multitrack step sequencer: track state and step table held in two RAMs.
// Tick: after the accept, each track passes TRK_RD and TRK_EVAL, a due track also STEP0
// and DECIDE, and FLUSH closes the tick; DECIDE and FLUSH wait while the output stalls.
// Start/stop/resume pass TRK_RD and TRK_EVAL; step write passes WSTEP; set divider waits
// in DIV for the bit-serial remainder, then passes TRK_RD and TRK_EVAL. After reset a
// clearing pass sweeps both RAMs; no item is taken until it ends.
module multitrack_step_sequencer_unit #(
    parameter int TRACKS = mss_pkg::TRACKS_DEF,
    parameter int STEPS  = mss_pkg::STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // opcode, track, step_index, step_kind, divider_value, tick_time, zero pad
    input  logic [mss_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // event_track, event_step, event_time
    output logic [mss_pkg::OUT_W-1:0] m_axis_tdata,
    // last_event
    output logic                      m_axis_tlast
);
    import mss_pkg::*;

    localparam int TB  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SB  = $clog2(STEPS);
    localparam int SAW = TB + SB;
    localparam int PW  = $clog2(STEPS + 1);
    localparam int TW  = 1 + PW + 2 * DIV_W;

    // input fields
    logic [OP_W-1:0]   in_op;
    logic [TRK_W-1:0]  in_trk;
    logic [SIDX_W-1:0] in_sidx;
    logic [KIND_W-1:0] in_kind;
    logic [DIV_W-1:0]  in_divv;
    logic [TIME_W-1:0] in_time;
    logic              in_accept;
    logic              in_trk_ok;
    logic              in_sidx_ok;

    assign in_op   = s_axis_tdata[2:0];
    assign in_trk  = s_axis_tdata[6:3];
    assign in_sidx = s_axis_tdata[10:7];
    assign in_kind = s_axis_tdata[12:11];
    assign in_divv = s_axis_tdata[20:13];
    assign in_time = s_axis_tdata[52:21];

    assign in_trk_ok  = {1'b0, in_trk} < (TRK_W + 1)'(TRACKS);
    assign in_sidx_ok = 7'(in_sidx) < 7'(STEPS);

    t_state            r_state, n_state;
    logic [SAW-1:0]    r_clr, n_clr;
    logic [TIME_W-1:0] r_tick, n_tick;
    logic [TB-1:0]     r_t, n_t;

    // item payload
    t_op               r_op;
    logic [SIDX_W-1:0] r_sidx;
    logic [KIND_W-1:0] r_kind_in;
    logic [DIV_W-1:0]  r_divv;
    logic [TIME_W-1:0] r_time;

    // current track fields
    logic [PW-1:0]     r_pos, n_pos;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W-1:0]  r_phase, n_phase;
    logic [KIND_W-1:0] r_k, n_k;

    // event held back until the next one shows whether it is the last
    logic              r_pend_valid, n_pend_valid;
    logic [TB-1:0]     r_pend_track, n_pend_track;
    logic [PW-1:0]     r_pend_step, n_pend_step;

    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              out_free;
    logic              out_push;
    logic              out_push_last;

    // track RAM
    logic              trk_we;
    logic              trk_re;
    logic [TB-1:0]     trk_addr;
    logic [TW-1:0]     trk_wdata;
    logic [TW-1:0]     trk_rdata;
    logic              q_play;
    logic [PW-1:0]     q_pos;
    logic [DIV_W-1:0]  q_div;
    logic [DIV_W-1:0]  q_phase;
    logic [DIV_W-1:0]  q_phase_inc;
    logic [DIV_W-1:0]  q_phase_next;

    // step RAM
    logic              stp_we;
    logic [SAW-1:0]    stp_waddr;
    logic [KIND_W-1:0] stp_wdata;
    logic              stp_re;
    logic [SAW-1:0]    stp_raddr;
    logic [KIND_W-1:0] stp_rdata;

    // remainder unit
    logic              mod_start;
    logic              mod_done;
    logic [DIV_W-1:0]  mod_rem;

    // decision of a due track
    logic [PW-1:0]     dec_pos;
    logic              dec_emit;

    assign q_play      = trk_rdata[TW-1];
    assign q_pos       = trk_rdata[TW-2 -: PW];
    assign q_div       = trk_rdata[2*DIV_W-1 -: DIV_W];
    assign q_phase     = trk_rdata[DIV_W-1:0];
    assign q_phase_inc = q_phase + DIV_W'(1);
    // phase tracks tick_count mod divider; the count wraps to zero after all ones
    assign q_phase_next = ((r_tick == '1) || (q_phase_inc == q_div)) ? '0 : q_phase_inc;

    assign dec_pos  = (r_k == KIND_JUMP) ? '0 : r_pos;
    assign dec_emit = (r_k != KIND_JUMP) || (stp_rdata != KIND_EMPTY);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mss_ram #(
        .WIDTH (TW),
        .DEPTH (1 << TB)
    ) u_trk_ram (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (trk_addr),
        .i_wdata (trk_wdata),
        .i_re    (trk_re),
        .i_raddr (trk_addr),
        .o_rdata (trk_rdata)
    );

    mss_ram #(
        .WIDTH (KIND_W),
        .DEPTH (1 << SAW)
    ) u_stp_ram (
        .i_clk   (i_clk),
        .i_we    (stp_we),
        .i_waddr (stp_waddr),
        .i_wdata (stp_wdata),
        .i_re    (stp_re),
        .i_raddr (stp_raddr),
        .o_rdata (stp_rdata)
    );

    mss_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_tick),
        .i_divisor  (in_divv),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_tick       = r_tick;
        n_t          = r_t;
        n_pos        = r_pos;
        n_div        = r_div;
        n_phase      = r_phase;
        n_k          = r_k;
        n_pend_valid = r_pend_valid;
        n_pend_track = r_pend_track;
        n_pend_step  = r_pend_step;
        out_push      = 1'b0;
        out_push_last = 1'b0;
        mod_start    = 1'b0;
        trk_we       = 1'b0;
        trk_re       = 1'b0;
        trk_addr     = r_t;
        trk_wdata    = {q_play, q_pos, q_div, q_phase};
        stp_we       = 1'b0;
        stp_waddr    = {r_t, SB'(r_sidx)};
        stp_wdata    = r_kind_in;
        stp_re       = 1'b0;
        stp_raddr    = {r_t, SB'(q_pos)};

        case (r_state)
            S_CLEAR: begin
                trk_we    = 1'b1;
                trk_addr  = r_clr[SAW-1 -: TB];
                trk_wdata = {1'b0, PW'(0), DIV_RESET, DIV_W'(0)};
                stp_we    = 1'b1;
                stp_waddr = r_clr;
                stp_wdata = KIND_EMPTY;
                n_clr     = r_clr + SAW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_t = TB'(in_trk);
                    case (t_op'(in_op))
                        OP_TICK: begin
                            n_t     = '0;
                            n_state = S_TRK_RD;
                        end
                        OP_START, OP_STOP, OP_RESUME: begin
                            if (in_trk_ok) begin
                                n_state = S_TRK_RD;
                            end
                        end
                        OP_WRITE: begin
                            if (in_trk_ok && in_sidx_ok) begin
                                n_state = S_WSTEP;
                            end
                        end
                        OP_DIVIDER: begin
                            if (in_trk_ok && (in_divv != '0)) begin
                                mod_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WSTEP: begin
                stp_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (mod_done) begin
                    n_state = S_TRK_RD;
                end
            end
            S_TRK_RD: begin
                trk_re  = 1'b1;
                n_state = S_TRK_EVAL;
            end
            S_TRK_EVAL: begin
                n_pos   = q_pos;
                n_div   = q_div;
                n_phase = q_phase_next;
                n_state = S_IDLE;
                case (r_op)
                    OP_TICK: begin
                        if (q_play && (q_phase == '0)) begin
                            stp_re  = 1'b1;
                            n_state = S_STEP0;
                        end else begin
                            trk_we    = 1'b1;
                            trk_wdata = {q_play, q_pos, q_div, q_phase_next};
                            if (r_t == TB'(TRACKS - 1)) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_t     = r_t + TB'(1);
                                n_state = S_TRK_RD;
                            end
                        end
                    end
                    OP_START: begin
                        trk_we    = 1'b1;
                        trk_wdata = {1'b1, PW'(0), q_div, q_phase};
                    end
                    OP_STOP: begin
                        trk_we    = 1'b1;
                        trk_wdata = {1'b0, q_pos, q_div, q_phase};
                    end
                    OP_RESUME: begin
                        trk_we    = 1'b1;
                        trk_wdata = {1'b1, q_pos, q_div, q_phase};
                    end
                    OP_DIVIDER: begin
                        trk_we    = 1'b1;
                        trk_wdata = {q_play, q_pos, r_divv, mod_rem};
                    end
                    default: begin
                    end
                endcase
            end
            S_STEP0: begin
                // end of table reads as an empty step
                n_k       = (r_pos < PW'(STEPS)) ? stp_rdata : KIND_EMPTY;
                stp_re    = 1'b1;
                stp_raddr = {r_t, SB'(0)};
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                // hold while a held event cannot move to the output
                if (!r_pend_valid || out_free) begin
                    trk_we = 1'b1;
                    if (r_k == KIND_EMPTY) begin
                        trk_wdata = {1'b0, r_pos, r_div, r_phase};
                    end else begin
                        trk_wdata = {1'b1, dec_pos + PW'(1), r_div, r_phase};
                        if (dec_emit) begin
                            out_push     = r_pend_valid;
                            n_pend_valid = 1'b1;
                            n_pend_track = r_t;
                            n_pend_step  = dec_pos;
                        end
                    end
                    if (r_t == TB'(TRACKS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_t     = r_t + TB'(1);
                        n_state = S_TRK_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_tick  = r_tick + TIME_W'(1);
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_push      = 1'b1;
                    out_push_last = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_tick        = r_tick + TIME_W'(1);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (out_push) begin
            n_out_valid = 1'b1;
            n_out_data  = {r_time, 4'(r_pend_step), 4'(r_pend_track)};
            n_out_last  = out_push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_tick       <= '0;
            r_t          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_tick       <= n_tick;
            r_t          <= n_t;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= t_op'(in_op);
            r_sidx    <= in_sidx;
            r_kind_in <= in_kind;
            r_divv    <= in_divv;
            r_time    <= in_time;
        end
        r_pos        <= n_pos;
        r_div        <= n_div;
        r_phase      <= n_phase;
        r_k          <= n_k;
        r_pend_track <= n_pend_track;
        r_pend_step  <= n_pend_step;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[tb/mss_event_checker.sv]
`timescale 1ns / 1ps
// Event checker for the multitrack step sequencer: watches both stream ports, predicts
// the events of every accepted item and compares them in arrival order.
// Depends on mss_pkg for widths, opcodes and step kinds.
module mss_event_checker #(
    parameter int TRACKS = mss_pkg::TRACKS_DEF,
    parameter int STEPS  = mss_pkg::STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    // opcode, track, step_index, step_kind, divider_value, tick_time, zero pad
    input  logic [mss_pkg::IN_W-1:0]  i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    // event_track, event_step, event_time
    input  logic [mss_pkg::OUT_W-1:0] i_out_data,
    input  logic                      i_out_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    import mss_pkg::*;

    typedef struct packed {
        logic [TRK_W-1:0]  trk;
        logic [SIDX_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } t_fire;

    logic              playing  [TRACKS];
    int                position [TRACKS];
    logic [DIV_W-1:0]  divider  [TRACKS];
    logic [KIND_W-1:0] kinds    [TRACKS][STEPS];
    logic [TIME_W-1:0] tick_count;
    t_fire             fire_q[$];
    int                failures = 0;

    // a position at the end of the table reads as an empty step
    function automatic logic [KIND_W-1:0] kind_of(input int t, input int pos);
        if (pos >= STEPS) return KIND_EMPTY;
        return kinds[t][pos];
    endfunction

    task automatic take_item(input logic [IN_W-1:0] d);
        logic [OP_W-1:0]   op;
        logic [TRK_W-1:0]  trk;
        logic [SIDX_W-1:0] sidx;
        logic [KIND_W-1:0] kind;
        logic [DIV_W-1:0]  divv;
        logic [TIME_W-1:0] stamp;
        t_fire             ev;
        t_fire             held;
        logic              have_held;
        int                pos;
        op    = d[2:0];
        trk   = d[6:3];
        sidx  = d[10:7];
        kind  = d[12:11];
        divv  = d[20:13];
        stamp = d[52:21];
        if (op == OP_TICK) begin
            have_held = 1'b0;
            held      = '0;
            for (int t = 0; t < TRACKS; t++) begin
                if (!playing[t] || (tick_count % divider[t]) != 0) continue;
                pos = position[t];
                if (kind_of(t, pos) == KIND_EMPTY) begin
                    playing[t] = 1'b0;
                    continue;
                end
                if (kind_of(t, pos) == KIND_JUMP) pos = 0;
                if (kind_of(t, pos) != KIND_EMPTY) begin
                    ev.trk   = TRK_W'(t);
                    ev.step  = SIDX_W'(pos);
                    ev.stamp = stamp;
                    ev.last  = 1'b0;
                    // hold back one event so the final one of the tick can be marked
                    if (have_held) fire_q.push_back(held);
                    held      = ev;
                    have_held = 1'b1;
                end
                pos++;
                if (pos > STEPS) pos = STEPS;
                position[t] = pos;
            end
            if (have_held) begin
                held.last = 1'b1;
                fire_q.push_back(held);
            end
            tick_count = tick_count + 1;
        end else if (trk < TRACKS) begin
            case (op)
                OP_START: begin
                    playing[trk]  = 1'b1;
                    position[trk] = 0;
                end
                OP_STOP:    playing[trk] = 1'b0;
                OP_RESUME:  playing[trk] = 1'b1;
                OP_WRITE: begin
                    if (sidx < STEPS) kinds[trk][sidx] = kind;
                end
                OP_DIVIDER: begin
                    if (divv != 0) divider[trk] = divv;
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_event(input logic [OUT_W-1:0] d, input logic lst);
        t_fire want;
        if (fire_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected event: track %0d step %0d time %h last %b",
                         $time, d[3:0], d[7:4], d[39:8], lst);
        end else begin
            want = fire_q.pop_front();
            if (d[3:0] !== want.trk || d[7:4] !== want.step || d[39:8] !== want.stamp ||
                lst !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: event mismatch: expected track %0d step %0d time %h last %b,%s",
                             $time, want.trk, want.step, want.stamp, want.last,
                             $sformatf(" got track %0d step %0d time %h last %b",
                                       d[3:0], d[7:4], d[39:8], lst));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                playing[t]  = 1'b0;
                position[t] = 0;
                divider[t]  = DIV_RESET;
                for (int s = 0; s < STEPS; s++) kinds[t][s] = KIND_EMPTY;
            end
            tick_count = '0;
            fire_q.delete();
        end else begin
            // results leaving now come from earlier items: compare before predicting
            if (i_out_valid && i_out_ready) check_event(i_out_data, i_out_last);
            if (i_in_valid && i_in_ready) take_item(i_in_data);
        end
        o_pending    <= fire_q.size();
        o_fail_count <= failures;
    end

endmodule

[tb/tb_multitrack_step_sequencer_unit.sv]
`timescale 1ns / 1ps
// Top of the multitrack step sequencer testbench: clock, reset, item stimulus with
// random bursts and stalls, watchdog and verdict. Depends on mss_pkg and mss_event_checker.
module tb_multitrack_step_sequencer_unit;
    import mss_pkg::*;

    localparam int TRACKS      = TRACKS_DEF;
    localparam int STEPS       = STEPS_DEF;
    localparam int ITEM_TARGET = 210;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 200;

    localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
    localparam logic [KIND_W-1:0] KIND_ALT    = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    int fail_count;
    int pending;
    int sent         = 0;
    int burst_left   = 0;
    int events_seen  = 0;
    int idle_cycles  = 0;

    multitrack_step_sequencer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mss_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // count events and watch for a stuck design
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) events_seen <= events_seen + 1;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("multitrack_step_sequencer_unit verification failed");
                $finish;
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold once events flow
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        bit hold_done;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && events_seen >= 20) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // offer one item; the sender works in bursts with random gaps between them
    task automatic send(input logic [OP_W-1:0] op, input int trk, input int sidx,
                        input logic [KIND_W-1:0] kind, input int divv,
                        input logic [TIME_W-1:0] stamp);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, stamp, DIV_W'(divv), kind, SIDX_W'(sidx), TRK_W'(trk), op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    // hold the sender until every predicted event has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int                trk;
        int                len;
        int                pick;
        int                ticks;
        bit                full;
        bit                paused;
        logic [KIND_W-1:0] kind;
        paused = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode, jumps, kind three, zero divider, empty stop, dead items
        send(OP_WRITE, 0, 0, KIND_EVENT, 0, '0);
        send(OP_WRITE, 0, 1, KIND_ALT, 0, '0);
        send(OP_WRITE, 0, 2, KIND_JUMP, 0, '0);
        send(OP_DIVIDER, 0, 0, KIND_EMPTY, 1, '0);
        send(OP_DIVIDER, 0, 0, KIND_EMPTY, 0, '0);
        send(OP_START, 0, 0, KIND_EMPTY, 0, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h0000_0000);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'hFFFF_FFFF);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h0000_0100);
        send(OP_STOP, 0, 0, KIND_EMPTY, 0, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h0000_0200);
        send(OP_RESUME, 0, 0, KIND_EMPTY, 0, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h8000_0000);
        send(OP_WRITE, 15, 15, KIND_ALT, 255, 32'hFFFF_FFFF);
        send(OP_SPARE_HI, 15, 15, KIND_ALT, 255, 32'hFFFF_FFFF);
        send(OP_SPARE_LO, 1, 1, KIND_EVENT, 1, 32'h0000_0001);
        send(OP_WRITE, 9, 0, KIND_JUMP, 0, '0);
        send(OP_DIVIDER, 9, 0, KIND_EMPTY, 1, '0);
        send(OP_START, 9, 0, KIND_EMPTY, 0, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h1234_5678);
        send(OP_DIVIDER, 1, 0, KIND_EMPTY, 1, '0);
        send(OP_START, 1, 0, KIND_EMPTY, 0, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h0000_0300);
        send(OP_DIVIDER, 9, 0, KIND_EMPTY, 255, '0);
        send(OP_TICK, 0, 0, KIND_EMPTY, 0, 32'h0000_0400);
        drain();

        // random: mostly short programs on one track followed by ticks, some noise
        while (sent < ITEM_TARGET) begin
            if (!paused && sent >= 120) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                trk  = $urandom_range(0, TRACKS - 1);
                full = ($urandom_range(0, 7) == 0);
                len  = full ? STEPS : $urandom_range(2, 6);
                for (int s = 0; s < len; s++) begin
                    pick = $urandom_range(0, 9);
                    if (full)                       kind = (pick < 8) ? KIND_EVENT : KIND_ALT;
                    else if (s == len - 1 && pick < 4) kind = KIND_JUMP;
                    else if (pick < 6)              kind = KIND_EVENT;
                    else if (pick < 7)              kind = KIND_ALT;
                    else if (pick < 8)              kind = KIND_EMPTY;
                    else                            kind = KIND_JUMP;
                    send(OP_WRITE, trk, s, kind, $urandom_range(0, 255), $urandom);
                end
                // full tables run at divider one so they reach the end of the table
                if (full || $urandom_range(0, 1))
                    send(OP_DIVIDER, trk, $urandom_range(0, 15), KIND_EMPTY,
                         full ? 1 : $urandom_range(1, 3), $urandom);
                send(($urandom_range(0, 4) == 0) ? OP_RESUME : OP_START, trk,
                     $urandom_range(0, 15), KIND_EMPTY, $urandom_range(0, 255), $urandom);
                ticks = full ? STEPS + 2 : $urandom_range(2, 8);
                repeat (ticks)
                    send(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 15),
                         KIND_W'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
            end else begin
                send(OP_W'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                     KIND_W'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("multitrack_step_sequencer_unit verification clean");
        end else begin
            $display("multitrack_step_sequencer_unit verification failed");
        end
        $finish;
    end

endmodule
